// ===== rtl/jcd_pkg.sv =====
// ----------------------------------------------------------------------------
// jcd_pkg
// shared types and constants of the joystick calibrate and direction core
// ----------------------------------------------------------------------------
package jcd_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int PCT_BITS    = 7;
    localparam int PROD_BITS   = SAMPLE_BITS + PCT_BITS;
    localparam int JOB_DEPTH   = 2;
    localparam int JOB_PTR_W   = $clog2(JOB_DEPTH);
    localparam int STEP_W      = $clog2(PCT_BITS);

    localparam logic [PCT_BITS-1:0]    PCT_FULL        = 7'd100;
    localparam logic [PROD_BITS-1:0]   PCT_FULL_W      = PROD_BITS'(100);
    localparam logic [PCT_BITS-1:0]    DEAD_ZONE_RESET = 7'd5;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_ALL_ONES = '1;

    localparam logic CMD_CALIBRATE = 1'b0;
    localparam logic CMD_MEASURE   = 1'b1;

    localparam logic [2:0] HEAD_NEUTRAL = 3'd0;
    localparam logic [2:0] HEAD_UP      = 3'd1;
    localparam logic [2:0] HEAD_DOWN    = 3'd2;
    localparam logic [2:0] HEAD_LEFT    = 3'd3;
    localparam logic [2:0] HEAD_RIGHT   = 3'd4;

    typedef struct packed {
        logic                   cmd;
        logic [SAMPLE_BITS-1:0] x_sample;
        logic [SAMPLE_BITS-1:0] y_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] x_percent;
        logic signed [7:0] y_percent;
        logic [2:0]        heading;
        logic              span_empty;
    } t_out_item;

    // one axis of a measure job, classified at the front
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mag;
        logic [SAMPLE_BITS-1:0] span;
        logic                   neg;
        logic                   empty;
    } t_axis_job;

    typedef struct packed {
        t_axis_job x;
        t_axis_job y;
    } t_job;

endpackage

// ===== rtl/jcd_fifo.sv =====
// ----------------------------------------------------------------------------
// jcd_fifo
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module jcd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  jcd_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_empty,
    output jcd_pkg::t_job o_job
);

    jcd_pkg::t_job                     r_mem [jcd_pkg::JOB_DEPTH];
    logic [jcd_pkg::JOB_PTR_W-1:0]     r_wr_ptr;
    logic [jcd_pkg::JOB_PTR_W-1:0]     r_rd_ptr;
    logic [jcd_pkg::JOB_PTR_W:0]       r_count;
    logic                              wr_en;
    logic                              rd_en;

    assign o_full  = (r_count == (jcd_pkg::JOB_PTR_W+1)'(jcd_pkg::JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == jcd_pkg::JOB_PTR_W'(jcd_pkg::JOB_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == jcd_pkg::JOB_PTR_W'(jcd_pkg::JOB_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/jcd_front.sv =====
// ----------------------------------------------------------------------------
// jcd_front
// accepts items, tracks calibration, turns measure items into divide jobs
// ----------------------------------------------------------------------------
module jcd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  jcd_pkg::t_in_item  i_item,
    output logic               o_job_wr,
    output jcd_pkg::t_job      o_job
);

    localparam int SB = jcd_pkg::SAMPLE_BITS;

    logic [SB-1:0] r_x_low, r_x_high, r_x_center;
    logic [SB-1:0] r_y_low, r_y_high, r_y_center;
    logic          cal;

    function automatic jcd_pkg::t_axis_job f_axis(
        input logic [SB-1:0] s,
        input logic [SB-1:0] lo,
        input logic [SB-1:0] hi,
        input logic [SB-1:0] ctr
    );
        jcd_pkg::t_axis_job j;
        j.neg = (s < ctr);
        if (s <= ctr) begin
            j.mag   = ctr - s;
            j.span  = ctr - lo;
            j.empty = (lo >= ctr);
        end else begin
            j.mag   = s - ctr;
            j.span  = hi - ctr;
            j.empty = (hi <= ctr);
        end
        return j;
    endfunction

    assign cal      = i_accept && (i_item.cmd == jcd_pkg::CMD_CALIBRATE);
    assign o_job_wr = i_accept && (i_item.cmd == jcd_pkg::CMD_MEASURE);
    assign o_job.x  = f_axis(i_item.x_sample, r_x_low, r_x_high, r_x_center);
    assign o_job.y  = f_axis(i_item.y_sample, r_y_low, r_y_high, r_y_center);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low    <= jcd_pkg::SAMPLE_ALL_ONES;
            r_x_high   <= '0;
            r_x_center <= '0;
            r_y_low    <= jcd_pkg::SAMPLE_ALL_ONES;
            r_y_high   <= '0;
            r_y_center <= '0;
        end else if (cal) begin
            // center latches from the first nonzero sample
            if (r_x_center == '0) begin
                r_x_center <= i_item.x_sample;
            end
            if (i_item.x_sample > r_x_high) begin
                r_x_high <= i_item.x_sample;
            end
            if (i_item.x_sample < r_x_low) begin
                r_x_low <= i_item.x_sample;
            end
            if (r_y_center == '0) begin
                r_y_center <= i_item.y_sample;
            end
            if (i_item.y_sample > r_y_high) begin
                r_y_high <= i_item.y_sample;
            end
            if (i_item.y_sample < r_y_low) begin
                r_y_low <= i_item.y_sample;
            end
        end
    end

endmodule

// ===== rtl/jcd_div.sv =====
// ----------------------------------------------------------------------------
// jcd_div
// restoring divider for one axis: 100 * mag / span, one quotient bit a step
// ----------------------------------------------------------------------------
module jcd_div (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_step,
    input  jcd_pkg::t_axis_job                i_job,
    output logic [jcd_pkg::PCT_BITS-1:0]      o_pct,
    output logic                              o_neg,
    output logic                              o_empty
);

    localparam int SB = jcd_pkg::SAMPLE_BITS;
    localparam int QB = jcd_pkg::PCT_BITS;

    logic [jcd_pkg::PROD_BITS-1:0] prod;
    logic [SB-1:0]                 r_rem;
    logic [SB-1:0]                 r_span;
    logic [QB-1:0]                 r_low;
    logic [QB-1:0]                 r_quot;
    logic                          r_over;
    logic                          r_neg;
    logic                          r_empty;
    logic [SB:0]                   trial;
    logic                          fits;

    assign prod  = jcd_pkg::PROD_BITS'(i_job.mag) * jcd_pkg::PCT_FULL_W;
    assign trial = {r_rem, r_low[QB-1]};
    assign fits  = (trial >= {1'b0, r_span});

    // mag above span means the quotient is above 100 and saturates
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem   <= prod[jcd_pkg::PROD_BITS-1:QB];
            r_low   <= prod[QB-1:0];
            r_span  <= i_job.span;
            r_quot  <= '0;
            r_over  <= (i_job.mag > i_job.span);
            r_neg   <= i_job.neg;
            r_empty <= i_job.empty;
        end else if (i_step) begin
            r_rem  <= fits ? SB'(trial - {1'b0, r_span}) : trial[SB-1:0];
            r_low  <= {r_low[QB-2:0], 1'b0};
            r_quot <= {r_quot[QB-2:0], fits};
        end
    end

    assign o_pct   = r_empty ? '0 : (r_over ? jcd_pkg::PCT_FULL : r_quot);
    assign o_neg   = r_neg && (o_pct != '0);
    assign o_empty = r_empty;

endmodule

// ===== rtl/jcd_back.sv =====
// ----------------------------------------------------------------------------
// jcd_back
// runs both axis dividers, classifies heading, holds the result register
// ----------------------------------------------------------------------------
module jcd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_empty,
    input  jcd_pkg::t_job                 i_job,
    output logic                          o_job_rd,
    input  logic [jcd_pkg::PCT_BITS-1:0]  i_dead_zone,
    output logic                          o_out_valid,
    input  logic                          i_out_pop,
    output jcd_pkg::t_out_item            o_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [jcd_pkg::STEP_W-1:0]   r_step, n_step;
    logic                         r_out_valid;
    jcd_pkg::t_out_item           r_out;
    logic                         load, step, out_free, out_wr;
    logic [jcd_pkg::PCT_BITS-1:0] x_pct, y_pct;
    logic                         x_neg, y_neg, x_empty, y_empty;
    jcd_pkg::t_out_item           res;

    jcd_div u_div_x (
        .i_clk   (i_clk),
        .i_load  (load),
        .i_step  (step),
        .i_job   (i_job.x),
        .o_pct   (x_pct),
        .o_neg   (x_neg),
        .o_empty (x_empty)
    );

    jcd_div u_div_y (
        .i_clk   (i_clk),
        .i_load  (load),
        .i_step  (step),
        .i_job   (i_job.y),
        .o_pct   (y_pct),
        .o_neg   (y_neg),
        .o_empty (y_empty)
    );

    assign load     = (r_state == ST_IDLE) && !i_job_empty;
    assign step     = (r_state == ST_RUN);
    assign out_free = !r_out_valid || i_out_pop;
    assign out_wr   = (r_state == ST_DONE) && out_free;
    assign o_job_rd = load;

    always_comb begin
        res.x_percent  = x_neg ? -$signed({1'b0, x_pct}) : $signed({1'b0, x_pct});
        res.y_percent  = y_neg ? -$signed({1'b0, y_pct}) : $signed({1'b0, y_pct});
        res.span_empty = x_empty || y_empty;
        if ((x_pct < i_dead_zone) && (y_pct < i_dead_zone)) begin
            res.heading = jcd_pkg::HEAD_NEUTRAL;
        end else if (x_pct <= y_pct) begin
            res.heading = y_neg ? jcd_pkg::HEAD_DOWN : jcd_pkg::HEAD_UP;
        end else begin
            res.heading = x_neg ? jcd_pkg::HEAD_LEFT : jcd_pkg::HEAD_RIGHT;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (load) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == jcd_pkg::STEP_W'(jcd_pkg::PCT_BITS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (out_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/joystick_calibrate_and_direction_core.sv =====
// ----------------------------------------------------------------------------
// joystick_calibrate_and_direction_core
// two-axis joystick calibration and percent / heading measurement
// ----------------------------------------------------------------------------
//  channel   | handshake                    | payload
//  ----------+------------------------------+---------------------------
//  input     | push / full                  | i_item  (cmd, x, y sample)
//  result    | empty / pop                  | o_item  (percents, heading,
//            |                              |          span_empty)
//  config    | i_cfg_valid / o_cfg_ready    | i_cfg_data (dead_zone)
//
//  a calibrate item is absorbed at its transfer edge and gives no result
//  a measure item is queued at its transfer edge; the dividers load it once
//  the back is idle, run 7 steps (one quotient bit each, both axes in
//  parallel), and the done state writes the result register when it is free;
//  a waiting result holds the back in its done state; the front keeps taking
//  items until the 2-deep job queue fills; reset is synchronous, active low
// ----------------------------------------------------------------------------
module joystick_calibrate_and_direction_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item input
    input  logic                              push,
    output logic                              full,
    input  jcd_pkg::t_in_item                 i_item,
    // result output
    output logic                              empty,
    input  logic                              pop,
    output jcd_pkg::t_out_item                o_item,
    // dead zone register write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [jcd_pkg::PCT_BITS-1:0]      i_cfg_data
);

    logic                         accept;
    logic                         job_wr;
    jcd_pkg::t_job                wr_job;
    logic                         job_rd;
    logic                         job_empty;
    jcd_pkg::t_job                rd_job;
    logic                         out_valid;
    logic [jcd_pkg::PCT_BITS-1:0] r_dead_zone;

    // an item transfer happens when push is high and the job queue has room
    assign accept = push && !full;

    jcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_job_wr (job_wr),
        .o_job    (wr_job)
    );

    jcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_job   (wr_job),
        .o_full  (full),
        .i_rd    (job_rd),
        .o_empty (job_empty),
        .o_job   (rd_job)
    );

    jcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (rd_job),
        .o_job_rd    (job_rd),
        .i_dead_zone (r_dead_zone),
        .o_out_valid (out_valid),
        .i_out_pop   (pop),
        .o_out       (o_item)
    );

    assign empty = !out_valid;

    // config transfer is always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= jcd_pkg::DEAD_ZONE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dead_zone <= i_cfg_data;
        end
    end

    // percents stay within the saturation range
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_item.x_percent <= 8'sd100) && (o_item.x_percent >= -8'sd100)
                && (o_item.y_percent <= 8'sd100) && (o_item.y_percent >= -8'sd100))
        else $error("percent out of range");

    // a left heading comes only from a negative horizontal percent
    a_left_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_item.heading == jcd_pkg::HEAD_LEFT)) |-> (o_item.x_percent < 0))
        else $error("left heading with non-negative x");

    // an empty span axis reports a zero percent, so a span_empty result has a zero percent
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_item.x_percent != 0) && (o_item.y_percent != 0))
            |-> !o_item.span_empty)
        else $error("span_empty with both axes nonzero");

endmodule
